@@ rtl/qweq_pkg.sv @@
// ----------------------------------------------------------------------------
// qweq_pkg
// Shared constants, codes and types of the queue with extreme queries.
// ----------------------------------------------------------------------------
package qweq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CAP_W  = 5;
  localparam int CNT_W  = 5;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [ACT_W-1:0] ACT_ENQ   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // control from the sequencer to the extremes tracker
  typedef struct packed {
    logic clear;
    logic sample;
  } ext_ctrl_t;

endpackage

@@ rtl/qweq_extremes.sv @@
// ----------------------------------------------------------------------------
// qweq_extremes
// Running largest, smallest, second largest and second smallest distinct
// values over a stream of entries, one entry per cycle while sample is held.
// ----------------------------------------------------------------------------
module qweq_extremes #(
  parameter int DATA_WIDTH = qweq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qweq_pkg::ext_ctrl_t          ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] key_i,
  output logic signed [DATA_WIDTH-1:0] max_o,
  output logic signed [DATA_WIDTH-1:0] min_o,
  output logic signed [DATA_WIDTH-1:0] max2_o,
  output logic signed [DATA_WIDTH-1:0] min2_o,
  output logic                         max2_ok_o,
  output logic                         min2_ok_o
);

  logic                         first_q;
  logic                         max2_ok_q, min2_ok_q;
  logic signed [DATA_WIDTH-1:0] max_q, min_q, max2_q, min2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= 1'b1;
      max2_ok_q <= 1'b0;
      min2_ok_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      first_q   <= 1'b1;
      max2_ok_q <= 1'b0;
      min2_ok_q <= 1'b0;
    end else if (ctrl_i.sample) begin
      first_q <= 1'b0;
      if (!first_q) begin
        if (key_i > max_q) begin
          max2_ok_q <= 1'b1;
        end else if (key_i < max_q && (!max2_ok_q || key_i > max2_q)) begin
          max2_ok_q <= 1'b1;
        end
        if (key_i < min_q) begin
          min2_ok_q <= 1'b1;
        end else if (key_i > min_q && (!min2_ok_q || key_i < min2_q)) begin
          min2_ok_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      max_q  <= '0;
      min_q  <= '0;
      max2_q <= '0;
      min2_q <= '0;
    end else if (ctrl_i.sample) begin
      if (first_q) begin
        max_q <= key_i;
        min_q <= key_i;
      end else begin
        // old maximum drops to second place when a new one arrives
        if (key_i > max_q) begin
          max2_q <= max_q;
          max_q  <= key_i;
        end else if (key_i < max_q && (!max2_ok_q || key_i > max2_q)) begin
          max2_q <= key_i;
        end
        if (key_i < min_q) begin
          min2_q <= min_q;
          min_q  <= key_i;
        end else if (key_i > min_q && (!min2_ok_q || key_i < min2_q)) begin
          min2_q <= key_i;
        end
      end
    end
  end

  assign max_o     = max_q;
  assign min_o     = min_q;
  assign max2_o    = max2_q;
  assign min2_o    = min2_q;
  assign max2_ok_o = max2_ok_q;
  assign min2_ok_o = min2_ok_q;

endmodule

@@ rtl/queue_with_extreme_queries_unit.sv @@
// ----------------------------------------------------------------------------
// queue_with_extreme_queries_unit
// Linear array queue of signed words with enqueue, dequeue and a query that
// scans the stored entries for the two largest and two smallest values.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | accepted when
//  ---------+-------------------------------------------+----------------------
//  input    | in_valid_i, in_ready_o, action_i, data    | in_valid_i & in_ready_o
//  result   | out_valid_o, out_ready_i, status_o ...    | out_valid_o & out_ready_i
//  config   | cfg_we_i, cfg_wdata_i                     | cfg_we_i
//
// One item at a time. Enqueue, rejected items and no-ops go from idle to the
// done state and the output register, a dequeue via a dequeue state (one entry
// memory read), a query via a scan state, in which the single read port of the
// entry memory delivers one entry per cycle to the extremes tracker. Reset
// empties the queue and sets capacity to 16; the entry memory is not cleared. A
// stalled result holds in the output register; the next result waits in S_DONE.
module queue_with_extreme_queries_unit #(
  parameter int DEPTH      = qweq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = qweq_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qweq_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [qweq_pkg::ACT_W-1:0]        action_i,
  input  logic signed [DATA_WIDTH-1:0]      data_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [qweq_pkg::STAT_W-1:0]       status_o,
  output logic signed [DATA_WIDTH-1:0]      read_value_o,
  output logic [qweq_pkg::CNT_W-1:0]        count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic signed [DATA_WIDTH-1:0]      back_value_o,
  output logic signed [DATA_WIDTH-1:0]      largest_value_o,
  output logic signed [DATA_WIDTH-1:0]      smallest_value_o,
  output logic signed [DATA_WIDTH-1:0]      second_largest_o,
  output logic signed [DATA_WIDTH-1:0]      second_smallest_o,
  output logic                              second_largest_ok_o,
  output logic                              second_smallest_ok_o
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (IW + 1 > qweq_pkg::CAP_W) ? IW + 1 : qweq_pkg::CAP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  logic [qweq_pkg::CAP_W-1:0] cap_q;
  logic [IW-1:0]              head_q, tail_q, ptr_q;
  logic                       empty_q, issue_q, rvld_q, rlast_q;
  logic signed [DATA_WIDTH-1:0] back_q, rd_q;
  logic [qweq_pkg::STAT_W-1:0]  stat_q;

  logic signed [DATA_WIDTH-1:0] entry_mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_rdata_q;
  logic                         mem_we, mem_re;
  logic [IW-1:0]                mem_wa, mem_ra;

  logic                out_valid_q;
  logic                out_load;
  logic                accept;
  logic [CMPW-1:0]     cap_ext, eff_cap, tail_next, count_full;
  logic                full;

  qweq_pkg::ext_ctrl_t          ext_ctrl;
  logic signed [DATA_WIDTH-1:0] ext_max, ext_min, ext_max2, ext_min2;
  logic                         ext_max2_ok, ext_min2_ok;

  // capacity: zero acts as one, anything above the built depth as the depth
  assign cap_ext = CMPW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(DEPTH)) begin
      eff_cap = CMPW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign tail_next  = CMPW'(tail_q) + CMPW'(1);
  assign full       = !empty_q && (tail_next >= eff_cap);
  assign count_full = CMPW'(tail_q) - CMPW'(head_q) + CMPW'(1);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // entry memory access
  assign mem_we = accept && (action_i == qweq_pkg::ACT_ENQ) && !full;
  assign mem_wa = empty_q ? '0 : tail_next[IW-1:0];
  assign mem_re = (accept && (action_i == qweq_pkg::ACT_DEQ) && !empty_q) ||
                  ((state_q == S_SCAN) && issue_q);
  assign mem_ra = (state_q == S_SCAN) ? ptr_q : head_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= data_value_i;
    end
    if (mem_re) begin
      mem_rdata_q <= entry_mem[mem_ra];
    end
  end

  assign ext_ctrl.clear  = accept;
  assign ext_ctrl.sample = (state_q == S_SCAN) && rvld_q;

  qweq_extremes #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_extremes (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ext_ctrl),
    .key_i     (mem_rdata_q),
    .max_o     (ext_max),
    .min_o     (ext_min),
    .max2_o    (ext_max2),
    .min2_o    (ext_min2),
    .max2_ok_o (ext_max2_ok),
    .min2_ok_o (ext_min2_ok)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == qweq_pkg::ACT_DEQ && !empty_q) begin
            state_d = S_DEQ;
          end else if (action_i == qweq_pkg::ACT_QUERY && !empty_q) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DEQ: begin
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (rvld_q && rlast_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= qweq_pkg::CAP_RESET;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      ptr_q   <= '0;
      issue_q <= 1'b0;
      rvld_q  <= 1'b0;
      rlast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      rvld_q  <= (state_q == S_SCAN) && issue_q;
      rlast_q <= (ptr_q == tail_q);
      if (accept) begin
        if (action_i == qweq_pkg::ACT_ENQ && !full) begin
          if (empty_q) begin
            head_q  <= '0;
            tail_q  <= '0;
            empty_q <= 1'b0;
          end else begin
            tail_q <= tail_next[IW-1:0];
          end
        end
        ptr_q   <= head_q;
        issue_q <= (action_i == qweq_pkg::ACT_QUERY) && !empty_q;
      end
      if (state_q == S_SCAN && issue_q) begin
        if (ptr_q == tail_q) begin
          issue_q <= 1'b0;
        end else begin
          ptr_q <= ptr_q + IW'(1);
        end
      end
      if (state_q == S_DEQ) begin
        // removing the last entry returns both indices to slot 0
        if (head_q >= tail_q) begin
          head_q  <= '0;
          tail_q  <= '0;
          empty_q <= 1'b1;
        end else begin
          head_q <= head_q + IW'(1);
        end
      end
    end
  end

  // pending item results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= '0;
      if (action_i == qweq_pkg::ACT_ENQ) begin
        stat_q <= full ? qweq_pkg::STAT_FULL : qweq_pkg::STAT_DONE;
      end else if ((action_i == qweq_pkg::ACT_DEQ || action_i == qweq_pkg::ACT_QUERY)
                   && empty_q) begin
        stat_q <= qweq_pkg::STAT_EMPTY;
      end else begin
        stat_q <= qweq_pkg::STAT_DONE;
      end
    end
    if (mem_we) begin
      back_q <= data_value_i;
    end
    if (state_q == S_DEQ) begin
      rd_q <= mem_rdata_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o             <= stat_q;
      read_value_o         <= rd_q;
      count_o              <= empty_q ? '0 : count_full[qweq_pkg::CNT_W-1:0];
      is_empty_o           <= empty_q;
      is_full_o            <= full;
      back_value_o         <= empty_q ? '0 : back_q;
      largest_value_o      <= ext_max;
      smallest_value_o     <= ext_min;
      second_largest_o     <= ext_max2;
      second_smallest_o    <= ext_min2;
      second_largest_ok_o  <= ext_max2_ok;
      second_smallest_ok_o <= ext_min2_ok;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the queue with extreme queries. A directed table
// covers the empty, single-entry, extreme-value and capacity corner cases,
// then random phases mix enqueue, dequeue, query and no-op items under
// changing capacity settings, bursty input and a stalling result side.
// Every result is compared field by field against a behavioral queue model,
// or against the table's expected result for fixed directed rows.
module tb_top;

  localparam int DW     = qweq_pkg::DATA_WIDTH_DEF;
  localparam int DEPTH  = qweq_pkg::DEPTH_DEF;
  localparam int ACT_W  = qweq_pkg::ACT_W;
  localparam int STAT_W = qweq_pkg::STAT_W;
  localparam int CNT_W  = qweq_pkg::CNT_W;
  localparam int CAP_W  = qweq_pkg::CAP_W;

  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  localparam logic [DW-1:0] VAL_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VAL_MIN  = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] VAL_NEG1 = {DW{1'b1}};

  localparam int RANDOM_ITEMS   = 800;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 1000000;

  typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_e;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DW-1:0]     read_value;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
    logic [DW-1:0]     back_value;
    logic [DW-1:0]     largest_value;
    logic [DW-1:0]     smallest_value;
    logic [DW-1:0]     second_largest;
    logic [DW-1:0]     second_smallest;
    logic              second_largest_ok;
    logic              second_smallest_ok;
  } queue_result_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [ACT_W-1:0]  action;
    logic [DW-1:0]     data;
    logic              fixed;
    queue_result_t     expected;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CAP_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [ACT_W-1:0]         action_i;
  logic signed [DW-1:0]     data_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [STAT_W-1:0]        status_o;
  logic signed [DW-1:0]     read_value_o;
  logic [CNT_W-1:0]         count_o;
  logic                     is_empty_o;
  logic                     is_full_o;
  logic signed [DW-1:0]     back_value_o;
  logic signed [DW-1:0]     largest_value_o;
  logic signed [DW-1:0]     smallest_value_o;
  logic signed [DW-1:0]     second_largest_o;
  logic signed [DW-1:0]     second_smallest_o;
  logic                     second_largest_ok_o;
  logic                     second_smallest_ok_o;

  queue_with_extreme_queries_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .data_value_i         (data_value_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .status_o             (status_o),
    .read_value_o         (read_value_o),
    .count_o              (count_o),
    .is_empty_o           (is_empty_o),
    .is_full_o            (is_full_o),
    .back_value_o         (back_value_o),
    .largest_value_o      (largest_value_o),
    .smallest_value_o     (smallest_value_o),
    .second_largest_o     (second_largest_o),
    .second_smallest_o    (second_smallest_o),
    .second_largest_ok_o  (second_largest_ok_o),
    .second_smallest_ok_o (second_smallest_ok_o)
  );

  // queue model state
  logic [DW-1:0]    shadow_store [DEPTH];
  int unsigned      shadow_head;
  int unsigned      shadow_tail;
  bit               shadow_empty;
  logic [CAP_W-1:0] shadow_capacity;

  queue_result_t awaited_results [$];
  queue_result_t front_result;
  stim_row_t     directed_rows [$];

  int error_count;
  int results_checked;
  int hold_off_request;
  int sent_per_action [4];
  int rejected_count;
  int capacity_writes;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic bit queue_is_full();
    int unsigned slots;
    if (shadow_capacity == 0) slots = 1;
    else if (shadow_capacity > DEPTH) slots = DEPTH;
    else slots = int'(shadow_capacity);
    return !shadow_empty && (shadow_tail + 1 >= slots);
  endfunction

  function automatic queue_result_t predict_queue_op(input logic [ACT_W-1:0] act,
                                                     input logic [DW-1:0] val);
    queue_result_t r;
    logic signed [DW-1:0] k, mx, mn, mx2, mn2;
    bit mx2_ok, mn2_ok;
    int unsigned i;
    r = '0;
    case (act)
      qweq_pkg::ACT_ENQ: begin
        if (queue_is_full()) begin
          r.status = qweq_pkg::STAT_FULL;
        end else begin
          if (shadow_empty) begin
            shadow_head  = 0;
            shadow_tail  = 0;
            shadow_empty = 1'b0;
          end else begin
            shadow_tail++;
          end
          shadow_store[shadow_tail] = val;
        end
      end
      qweq_pkg::ACT_DEQ: begin
        if (shadow_empty) begin
          r.status = qweq_pkg::STAT_EMPTY;
        end else begin
          r.read_value = shadow_store[shadow_head];
          if (shadow_head >= shadow_tail) begin
            shadow_head  = 0;
            shadow_tail  = 0;
            shadow_empty = 1'b1;
          end else begin
            shadow_head++;
          end
        end
      end
      qweq_pkg::ACT_QUERY: begin
        if (shadow_empty) begin
          r.status = qweq_pkg::STAT_EMPTY;
        end else begin
          mx = shadow_store[shadow_head];
          mn = mx;
          mx2 = '0;
          mn2 = '0;
          mx2_ok = 1'b0;
          mn2_ok = 1'b0;
          for (i = shadow_head + 1; i <= shadow_tail; i++) begin
            k = shadow_store[i];
            if (k > mx) begin
              mx2 = mx;
              mx2_ok = 1'b1;
              mx = k;
            end else if (k < mx && (!mx2_ok || k > mx2)) begin
              mx2 = k;
              mx2_ok = 1'b1;
            end
            if (k < mn) begin
              mn2 = mn;
              mn2_ok = 1'b1;
              mn = k;
            end else if (k > mn && (!mn2_ok || k < mn2)) begin
              mn2 = k;
              mn2_ok = 1'b1;
            end
          end
          r.largest_value      = mx;
          r.smallest_value     = mn;
          r.second_largest     = mx2_ok ? mx2 : '0;
          r.second_smallest    = mn2_ok ? mn2 : '0;
          r.second_largest_ok  = mx2_ok;
          r.second_smallest_ok = mn2_ok;
        end
      end
      default: ;
    endcase
    r.count      = shadow_empty ? '0 : CNT_W'(shadow_tail - shadow_head + 1);
    r.is_empty   = shadow_empty;
    r.is_full    = queue_is_full();
    r.back_value = shadow_empty ? '0 : shadow_store[shadow_tail];
    return r;
  endfunction

  function automatic queue_result_t mk_result(
      input logic [STAT_W-1:0] status, input logic [DW-1:0] rd,
      input logic [CNT_W-1:0] cnt, input logic emp, input logic ful,
      input logic [DW-1:0] back, input logic [DW-1:0] lg, input logic [DW-1:0] sm,
      input logic [DW-1:0] lg2, input logic [DW-1:0] sm2,
      input logic lg2_ok, input logic sm2_ok);
    queue_result_t r;
    r.status             = status;
    r.read_value         = rd;
    r.count              = cnt;
    r.is_empty           = emp;
    r.is_full            = ful;
    r.back_value         = back;
    r.largest_value      = lg;
    r.smallest_value     = sm;
    r.second_largest     = lg2;
    r.second_smallest    = sm2;
    r.second_largest_ok  = lg2_ok;
    r.second_smallest_ok = sm2_ok;
    return r;
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [ACT_W-1:0] act,
                                  input logic [DW-1:0] val, input logic fixed,
                                  input queue_result_t res);
    stim_row_t row;
    row.kind     = kind;
    row.action   = act;
    row.data     = val;
    row.fixed    = fixed;
    row.expected = res;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return DW'($urandom);
      2:       return DW'(int'($urandom_range(0, 6)) - 3);
      3:       return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      4:       return $urandom_range(0, 1) ? '0 : VAL_NEG1;
      default: return DW'(100 + $urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 6))
      0:       return 5'd1;
      1:       return 5'd2;
      2:       return 5'd16;
      3:       return 5'd31;
      4:       return 5'd0;
      5:       return CAP_W'($urandom_range(17, 31));
      default: return CAP_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [DW-1:0] exp_v,
                             input logic [DW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      error_count++;
    end
  endtask

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [DW-1:0] val,
                           input logic fixed, input queue_result_t fixed_res);
    queue_result_t pred;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    data_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = predict_queue_op(act, val);
    awaited_results.push_back(fixed ? fixed_res : pred);
    sent_per_action[act]++;
    if (pred.status != qweq_pkg::STAT_DONE) rejected_count++;
  endtask

  task automatic idle_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic settle_queue();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_capacity = cap;
    capacity_writes++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        error_count++;
      end else begin
        front_result = awaited_results.pop_front();
        check_field("status", DW'(front_result.status), DW'(status_o));
        check_field("read_value", front_result.read_value, read_value_o);
        check_field("count", DW'(front_result.count), DW'(count_o));
        check_field("is_empty", DW'(front_result.is_empty), DW'(is_empty_o));
        check_field("is_full", DW'(front_result.is_full), DW'(is_full_o));
        check_field("back_value", front_result.back_value, back_value_o);
        check_field("largest_value", front_result.largest_value, largest_value_o);
        check_field("smallest_value", front_result.smallest_value, smallest_value_o);
        check_field("second_largest", front_result.second_largest, second_largest_o);
        check_field("second_smallest", front_result.second_smallest, second_smallest_o);
        check_field("second_largest_ok", DW'(front_result.second_largest_ok),
                    DW'(second_largest_ok_o));
        check_field("second_smallest_ok", DW'(front_result.second_smallest_ok),
                    DW'(second_smallest_ok_o));
        results_checked++;
      end
    end
  end

  // result side: randomly chosen stall patterns and requested long holds
  initial begin : result_sink
    int mode;
    int left;
    int tick;
    int hold;
    tick = 0;
    out_ready_i <= 1'b0;
    forever begin
      if (hold_off_request != 0) begin
        hold = hold_off_request;
        hold_off_request = 0;
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      mode = $urandom_range(0, 4);
      left = $urandom_range(16, 96);
      while (left > 0 && hold_off_request == 0) begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= $urandom_range(0, 1);
          2:       out_ready_i <= ($urandom_range(0, 7) != 0);
          3:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (tick % 5 != 0);
        endcase
        @(posedge clk_i);
        tick++;
        left--;
      end
    end
  end

  initial begin : watchdog
    #WATCHDOG_LIMIT;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int items_left;
    int phase;
    int phase_len;
    int mix;
    int roll;
    int burst_left;
    bit gaps_on;
    logic [ACT_W-1:0] act;
    int enq_pct [3];
    int deq_pct [3];

    enq_pct = '{70, 40, 15};
    deq_pct = '{85, 75, 75};
    error_count      = 0;
    results_checked  = 0;
    hold_off_request = 0;
    rejected_count   = 0;
    capacity_writes  = 0;
    sent_per_action  = '{0, 0, 0, 0};
    shadow_head      = 0;
    shadow_tail      = 0;
    shadow_empty     = 1'b1;
    shadow_capacity  = qweq_pkg::CAP_RESET;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    action_i     <= qweq_pkg::ACT_ENQ;
    data_value_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, then the two signed extremes
    add_row(ROW_ITEM, qweq_pkg::ACT_DEQ, '0, 1'b1,
            mk_result(qweq_pkg::STAT_EMPTY, '0, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0,
                      1'b0, 1'b0));
    add_row(ROW_ITEM, qweq_pkg::ACT_QUERY, '0, 1'b1,
            mk_result(qweq_pkg::STAT_EMPTY, '0, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0,
                      1'b0, 1'b0));
    add_row(ROW_ITEM, ACT_NOP, VAL_NEG1, 1'b1,
            mk_result(qweq_pkg::STAT_DONE, '0, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0,
                      1'b0, 1'b0));
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, VAL_MAX, 1'b1,
            mk_result(qweq_pkg::STAT_DONE, '0, 5'd1, 1'b0, 1'b0, VAL_MAX, '0, '0, '0, '0,
                      1'b0, 1'b0));
    add_row(ROW_ITEM, qweq_pkg::ACT_QUERY, '0, 1'b1,
            mk_result(qweq_pkg::STAT_DONE, '0, 5'd1, 1'b0, 1'b0, VAL_MAX, VAL_MAX, VAL_MAX,
                      '0, '0, 1'b0, 1'b0));
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, VAL_MIN, 1'b1,
            mk_result(qweq_pkg::STAT_DONE, '0, 5'd2, 1'b0, 1'b0, VAL_MIN, '0, '0, '0, '0,
                      1'b0, 1'b0));
    add_row(ROW_ITEM, qweq_pkg::ACT_QUERY, '0, 1'b1,
            mk_result(qweq_pkg::STAT_DONE, '0, 5'd2, 1'b0, 1'b0, VAL_MIN, VAL_MAX, VAL_MIN,
                      VAL_MIN, VAL_MAX, 1'b1, 1'b1));
    // duplicates around zero
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, '0, 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, VAL_NEG1, 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, VAL_NEG1, 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_QUERY, '0, 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_DEQ, '0, 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_QUERY, '0, 1'b0, '0);
    // capacity dropped below the tail: full until emptied
    add_row(ROW_CAPACITY, qweq_pkg::ACT_ENQ, DW'(1), 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, DW'(9), 1'b0, '0);
    repeat (4) add_row(ROW_ITEM, qweq_pkg::ACT_DEQ, '0, 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, DW'(5), 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, DW'(6), 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_QUERY, '0, 1'b0, '0);
    // out-of-range capacity acts as the full depth
    add_row(ROW_CAPACITY, qweq_pkg::ACT_ENQ, DW'(31), 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_ENQ, DW'(7), 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_DEQ, '0, 1'b0, '0);
    add_row(ROW_ITEM, qweq_pkg::ACT_DEQ, '0, 1'b0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAPACITY) begin
        settle_queue();
        write_capacity(directed_rows[i].data[CAP_W-1:0]);
      end else begin
        send_item(directed_rows[i].action, directed_rows[i].data,
                  directed_rows[i].fixed, directed_rows[i].expected);
      end
    end

    items_left = RANDOM_ITEMS;
    phase = 0;
    while (items_left > 0) begin
      phase_len = $urandom_range(30, 70);
      if (phase_len > items_left) phase_len = items_left;
      if (phase == 1 || phase == 2 || (phase > 2 && $urandom_range(0, 9) < 6)) begin
        settle_queue();
        if (phase == 1) write_capacity(5'd0);
        else if (phase == 2) write_capacity(5'd16);
        else write_capacity(pick_capacity());
      end
      mix = $urandom_range(0, 2);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // long result stall while items keep coming
        gaps_on = 1'b0;
        hold_off_request = LONG_HOLD;
      end
      burst_left = 0;
      repeat (phase_len) begin
        if (gaps_on) begin
          if (burst_left == 0) begin
            idle_sender($urandom_range(1, 12));
            burst_left = $urandom_range(1, 20);
          end
          burst_left--;
        end
        roll = $urandom_range(0, 99);
        if (roll < enq_pct[mix]) act = qweq_pkg::ACT_ENQ;
        else if (roll < deq_pct[mix]) act = qweq_pkg::ACT_DEQ;
        else if (roll < 97) act = qweq_pkg::ACT_QUERY;
        else act = ACT_NOP;
        send_item(act, (act == qweq_pkg::ACT_ENQ) ? pick_value() : DW'($urandom),
                  1'b0, '0);
      end
      items_left -= phase_len;
      phase++;
    end

    settle_queue();
    repeat (24) @(posedge clk_i);
    $display("covered %0d enqueue, %0d dequeue, %0d query and %0d no-op items, %0d rejected",
             sent_per_action[qweq_pkg::ACT_ENQ], sent_per_action[qweq_pkg::ACT_DEQ],
             sent_per_action[qweq_pkg::ACT_QUERY], sent_per_action[ACT_NOP],
             rejected_count);
    $display("%0d results checked across %0d capacity writes, %0d errors",
             results_checked, capacity_writes, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
